@@ rtl/core/awd_pkg.sv @@
// Shared constants and types for the audio waveshaper distortion block.
// No dependencies; imported by every module of the block.
package awd_pkg;

	localparam int AWD_SAMPLE_WIDTH = 16;
	localparam int DRIVE_W          = 7;
	localparam int AMT_W            = 8;
	localparam int AMT_FULL         = 128;
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_AMOUNT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLIP_MODE    = 1'd1;

	localparam logic MODE_SOFT = 1'b0;
	localparam logic MODE_HARD = 1'b1;

	// Per-item side information that rides along the pipeline.
	typedef struct packed {
		logic hard;
		logic neg;
		logic blk;
		logic ovf;
	} awd_flags_t;

endpackage

@@ rtl/core/awd_prep.sv @@
// Operand formation: magnitude, drive products, dividend and divisor.
// Depends on awd_pkg. Three pipeline stages with a ready chain.
module awd_prep #(
	parameter int SAMPLE_WIDTH = awd_pkg::AWD_SAMPLE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
	input  logic                              block_end,
	input  logic [awd_pkg::DRIVE_W-1:0]       drive,
	input  logic                              mode,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2*SAMPLE_WIDTH+6:0]         dvd,
	output logic [SAMPLE_WIDTH+7:0]           dvs,
	output awd_pkg::awd_flags_t               flags
);
	import awd_pkg::*;

	localparam int W  = SAMPLE_WIDTH;
	localparam int PW = W + AMT_W;
	localparam int AW = 2 * W + 7;
	localparam int BW = W + AMT_W;

	logic                v_s1, v_s2, v_s3;
	logic                rdy_s1, rdy_s2, rdy_s3;
	logic [W-1:0]        mag_s1;
	logic [DRIVE_W-1:0]  drive_s1;
	awd_flags_t          flg_s1, flg_s2, flg_s3;
	logic [PW-1:0]       p_s2, t_s2;
	logic [AMT_W-1:0]    d_s2;
	logic [AW-1:0]       a_s3;
	logic [BW-1:0]       b_s3;

	logic [W-1:0]        mag_in;
	logic [AMT_W-1:0]    gain_hi;
	logic [AW-1:0]       a_soft;
	logic [BW-1:0]       b_soft;
	logic                hard_ovf;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Magnitude; the most negative code wraps to its positive magnitude.
	assign mag_in  = sample_in[W-1] ? (~W'(sample_in) + W'(1)) : W'(sample_in);
	assign gain_hi = AMT_W'(AMT_FULL) + {1'b0, drive_s1};

	// x * full scale is (x << (W-1)) - x.
	assign a_soft = (AW'(p_s2) << (W - 1)) - AW'(p_s2);
	assign b_soft = (BW'(d_s2) << (W - 1)) - BW'(d_s2) + BW'(t_s2);
	assign hard_ovf = AW'(t_s2) >= (AW'(d_s2) << (W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			mag_s1     <= mag_in;
			drive_s1   <= drive;
			flg_s1.hard <= (mode == MODE_HARD);
			flg_s1.neg <= sample_in[W-1];
			flg_s1.blk <= block_end;
			flg_s1.ovf <= 1'b0;
		end
		if (rdy_s2) begin
			p_s2   <= PW'(gain_hi) * PW'(mag_s1);
			t_s2   <= PW'({drive_s1, 1'b0}) * PW'(mag_s1);
			d_s2   <= AMT_W'(AMT_FULL) - {1'b0, drive_s1};
			flg_s2 <= flg_s1;
		end
		if (rdy_s3) begin
			a_s3   <= flg_s2.hard ? AW'(t_s2) : a_soft;
			b_s3   <= flg_s2.hard ? BW'(d_s2) : b_soft;
			flg_s3 <= '{hard: flg_s2.hard, neg: flg_s2.neg, blk: flg_s2.blk,
				ovf: flg_s2.hard && hard_ovf};
		end
	end

	assign out_valid = v_s3;
	assign dvd       = a_s3;
	assign dvs       = b_s3;
	assign flags     = flg_s3;

endmodule

@@ rtl/core/awd_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// Depends on awd_pkg for the flag struct.
module awd_div #(
	parameter int SAMPLE_WIDTH = awd_pkg::AWD_SAMPLE_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2*SAMPLE_WIDTH+6:0]   dvd,
	input  logic [SAMPLE_WIDTH+7:0]     dvs,
	input  awd_pkg::awd_flags_t         flags_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [SAMPLE_WIDTH-1:0]     quo,
	output awd_pkg::awd_flags_t         flags_out
);
	import awd_pkg::*;

	localparam int W  = SAMPLE_WIDTH;
	localparam int AW = 2 * W + 7;
	localparam int BW = W + AMT_W;

	logic             v_s   [W+1];
	logic             rdy_s [W+1];
	logic [AW-1:0]    rem_s [W+1];
	logic [BW-1:0]    dvs_s [W+1];
	logic [W-1:0]     quo_s [W+1];
	awd_flags_t       flg_s [W+1];

	// Slot 0 is the incoming operand set, slots 1..W are the stage registers.
	assign v_s[0]   = in_valid;
	assign rem_s[0] = dvd;
	assign dvs_s[0] = dvs;
	assign quo_s[0] = '0;
	assign flg_s[0] = flags_in;
	assign in_ready = rdy_s[0];
	assign rdy_s[W] = out_ready;

	genvar j;
	generate
		for (j = 0; j < W; j++) begin : g_stage
			localparam int BIT = W - 1 - j;
			logic [AW-1:0] trial;
			logic          take;

			assign trial      = AW'(dvs_s[j]) << BIT;
			assign take       = rem_s[j] >= trial;
			assign rdy_s[j]   = !v_s[j+1] || rdy_s[j+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[j+1] <= 1'b0;
				end else if (rdy_s[j]) begin
					v_s[j+1] <= v_s[j];
				end
			end

			// Lower quotient bits are still clear here; set this stage's bit.
			always_ff @(posedge clk) begin
				if (rdy_s[j]) begin
					rem_s[j+1] <= take ? (rem_s[j] - trial) : rem_s[j];
					dvs_s[j+1] <= dvs_s[j];
					quo_s[j+1] <= quo_s[j] | (W'(take) << BIT);
					flg_s[j+1] <= flg_s[j];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[W];
	assign quo       = quo_s[W];
	assign flags_out = flg_s[W];

endmodule

@@ rtl/core/awd_post.sv @@
// Output stage: clamp for hard mode, restore sign, hold the result item.
// Depends on awd_pkg for the flag struct.
module awd_post #(
	parameter int SAMPLE_WIDTH = awd_pkg::AWD_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [SAMPLE_WIDTH-1:0]        quo,
	input  awd_pkg::awd_flags_t            flags,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           block_end_out
);
	import awd_pkg::*;

	localparam int W = SAMPLE_WIDTH;
	localparam logic [W-1:0] FULL_SCALE = {1'b0, {(W-1){1'b1}}};

	logic         v_s5;
	logic [W-1:0] y_s5;
	logic         blk_s5;
	logic [W-1:0] mag;

	assign in_ready = !v_s5 || !out_stall;
	assign mag      = flags.ovf ? FULL_SCALE : quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (in_ready) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			y_s5   <= flags.neg ? (~mag + W'(1)) : mag;
			blk_s5 <= flags.blk;
		end
	end

	assign out_valid     = v_s5;
	assign sample_out    = y_s5;
	assign block_end_out = blk_s5;

endmodule

@@ rtl/core/audio_waveshaper_distortion.sv @@
// Top level of the rational waveshaper / soft clipper.
// Depends on awd_pkg, awd_prep, awd_div and awd_post.
//
// Distorts one signed sample per item at drive k = 2s/(128-s), s = drive_amount.
// Soft mode gives y = (128+s)*n*F / (F*(128-s) + 2s*|n|) with F the positive
// full scale; hard mode gives 2s*n/(128-s) clamped to +/-F without inversion.
// Results truncate toward zero and block_end passes through with its sample.
// Throughput is one item per clock while out_stall is low. The pipeline has three
// operand stages, one restoring divider stage per quotient bit and one output
// register. Stalls collapse bubbles: each stage loads whenever the stage after it
// is empty or moving, so new items keep entering while a finished one waits at
// the output.
// Write drive_amount and clip_mode only while no item is in flight; they are
// sampled as an item enters the first stage.
module audio_waveshaper_distortion #(
	parameter int SAMPLE_WIDTH = awd_pkg::AWD_SAMPLE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [awd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [awd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]     sample_in,
	input  logic                               block_end,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]     sample_out,
	output logic                               block_end_out
);
	import awd_pkg::*;

	localparam int W  = SAMPLE_WIDTH;
	localparam int AW = 2 * W + 7;
	localparam int BW = W + AMT_W;

	logic [DRIVE_W-1:0] drive_q;
	logic               mode_q;

	logic               prep_ready;
	logic               prep_valid, div_ready;
	logic [AW-1:0]      dvd;
	logic [BW-1:0]      dvs;
	awd_flags_t         prep_flags;
	logic               div_valid, post_ready;
	logic [W-1:0]       quo;
	awd_flags_t         div_flags;

	// Configuration registers: take the write, drop bits above each width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
			mode_q  <= MODE_SOFT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DRIVE_AMOUNT: drive_q <= cfg_data[DRIVE_W-1:0];
				REG_CLIP_MODE:    mode_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = !prep_ready;

	// Build dividend and divisor for the selected mode.
	awd_prep #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (prep_ready),
		.sample_in (sample_in),
		.block_end (block_end),
		.drive     (drive_q),
		.mode      (mode_q),
		.out_valid (prep_valid),
		.out_ready (div_ready),
		.dvd       (dvd),
		.dvs       (dvs),
		.flags     (prep_flags)
	);

	// Divide magnitudes, one quotient bit per stage.
	awd_div #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (div_ready),
		.dvd       (dvd),
		.dvs       (dvs),
		.flags_in  (prep_flags),
		.out_valid (div_valid),
		.out_ready (post_ready),
		.quo       (quo),
		.flags_out (div_flags)
	);

	// Clamp, restore the sign and hold the result item for the consumer.
	awd_post #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (div_valid),
		.in_ready      (post_ready),
		.quo           (quo),
		.flags         (div_flags),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.block_end_out (block_end_out)
	);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for audio_waveshaper_distortion: a directed table, then random
// phases under several drive/mode settings, checked against typed answers or an in-bench model.
// Depends on awd_pkg and the block's RTL only.
module tb_top;
	import awd_pkg::*;

	localparam int SW = AWD_SAMPLE_WIDTH;
	localparam longint FS = (64'sd1 <<< (SW - 1)) - 1;  // positive full scale
	localparam int N_PHASES = 12;
	localparam int PHASE_ITEMS = 128;
	localparam int HOLD_CYCLES = 400;                   // long output hold-off
	localparam int TAIL_CYCLES = SW + 4 + 12;           // pipeline depth plus margin

	// One expected result: shaped sample plus the block-end flag riding along.
	typedef struct packed {
		logic signed [SW-1:0] smp;
		logic                 blk;
	} shaped_t;

	// Directed row: raw register data, the item, and an optional typed-in answer.
	typedef struct packed {
		logic [CFG_DATA_W-1:0] drive_raw;
		logic [CFG_DATA_W-1:0] mode_raw;
		logic signed [15:0]    smp;
		logic                  blk;
		logic                  typed;
		logic signed [15:0]    want;
	} shape_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic block_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;
	logic block_end_out;

	shaped_t shaped_q[$];          // expectations, oldest first
	logic [DRIVE_W-1:0] cur_drive = '0;
	logic cur_mode = MODE_SOFT;
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int ends_sent = 0;
	int settings_used = 0;
	int holds_done = 0;
	bit squeeze_req = 1'b0;

	// Rows with a typed answer are read straight off the transfer function:
	// zero drive passes soft samples through and zeroes hard ones, s=127 hard
	// is 254*n clamped, and s=64 hard is 2*n clamped.
	shape_row_t shape_rows [24] = '{
		'{7'd0,   {6'h00, MODE_SOFT},  16'sd32767,  1'b0, 1'b1, 16'sd32767},
		'{7'd0,   {6'h00, MODE_SOFT}, -16'sd32768,  1'b1, 1'b1, -16'sd32768},
		'{7'd0,   {6'h00, MODE_SOFT},  16'sd0,      1'b0, 1'b1, 16'sd0},
		'{7'd0,   {6'h00, MODE_SOFT}, -16'sd1,      1'b1, 1'b1, -16'sd1},
		'{7'd0,   {6'h00, MODE_SOFT},  16'sd12345,  1'b0, 1'b1, 16'sd12345},
		'{7'd0,   {6'h3F, MODE_HARD},  16'sd32767,  1'b1, 1'b1, 16'sd0},
		'{7'd0,   {6'h00, MODE_HARD}, -16'sd32768,  1'b0, 1'b1, 16'sd0},
		'{7'd127, {6'h00, MODE_HARD},  16'sd32767,  1'b0, 1'b1, 16'sd32767},
		'{7'd127, {6'h00, MODE_HARD}, -16'sd32768,  1'b1, 1'b1, -16'sd32767},
		'{7'd127, {6'h00, MODE_HARD},  16'sd1,      1'b0, 1'b1, 16'sd254},
		'{7'd127, {6'h00, MODE_HARD}, -16'sd1,      1'b1, 1'b1, -16'sd254},
		'{7'd127, {6'h00, MODE_HARD},  16'sd0,      1'b0, 1'b1, 16'sd0},
		'{7'd127, {6'h2A, MODE_SOFT},  16'sd32767,  1'b1, 1'b1, 16'sd32767},
		'{7'd127, {6'h00, MODE_SOFT}, -16'sd32768,  1'b0, 1'b0, 16'sd0},
		'{7'd127, {6'h00, MODE_SOFT},  16'sd1,      1'b1, 1'b0, 16'sd0},
		'{7'd127, {6'h00, MODE_SOFT}, -16'sd1,      1'b0, 1'b0, 16'sd0},
		'{7'd127, {6'h00, MODE_SOFT}, -16'sd32767,  1'b1, 1'b1, -16'sd32767},
		'{7'd64,  {6'h00, MODE_HARD},  16'sd16383,  1'b0, 1'b1, 16'sd32766},
		'{7'd64,  {6'h00, MODE_HARD},  16'sd16384,  1'b1, 1'b1, 16'sd32767},
		'{7'd64,  {6'h00, MODE_HARD}, -16'sd16384,  1'b0, 1'b1, -16'sd32767},
		'{7'd64,  {6'h00, MODE_SOFT},  16'sd16384,  1'b1, 1'b0, 16'sd0},
		'{7'd1,   {6'h00, MODE_SOFT}, -16'sd32768,  1'b0, 1'b0, 16'sd0},
		'{7'd1,   {6'h00, MODE_HARD},  16'sd100,    1'b1, 1'b0, 16'sd0},
		'{7'd126, {6'h00, MODE_SOFT}, -16'sd12345,  1'b0, 1'b0, 16'sd0}
	};

	audio_waveshaper_distortion u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_in     (sample_in),
		.block_end     (block_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.block_end_out (block_end_out)
	);

	// 4-unit clock, high then low.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shape one sample exactly: rational soft clip, or driven and clamped hard clip.
	// Both divisions truncate toward zero, as SystemVerilog signed division does.
	function automatic logic signed [SW-1:0] shape_sample(input logic [DRIVE_W-1:0] amt,
			input logic mode, input logic signed [SW-1:0] n);
		longint s;
		longint x;
		longint mag;
		longint y;
		s = longint'(amt);
		x = longint'(n);
		if (mode == MODE_HARD) begin
			y = (2 * s * x) / (128 - s);
			if (y > FS)
				y = FS;
			if (y < -FS)
				y = -FS;
		end else begin
			mag = (x < 0) ? -x : x;
			y = ((128 + s) * x * FS) / (FS * (128 - s) + 2 * s * mag);
		end
		return y[SW-1:0];
	endfunction

	// Draw a sample: mostly full-range, with extremes, small values and values
	// right at the hard-clip knee mixed in.
	function automatic logic signed [SW-1:0] pick_sample(input logic [DRIVE_W-1:0] amt);
		longint knee;
		logic signed [SW-1:0] v;
		v = SW'($urandom());
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: v = SW'(FS);
					1: v = SW'(-FS - 1);
					2: v = SW'(-FS);
					3: v = '0;
					4: v = SW'(1);
					default: v = '1;
				endcase
			end
			1: begin
				v = SW'($urandom_range(0, 255));
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			2: begin
				if (amt != 0) begin
					knee = (FS * (128 - longint'(amt))) / (2 * longint'(amt));
					knee = knee + longint'($urandom_range(0, 4)) - 2;
					if (knee > FS)
						knee = FS;
					v = $urandom_range(0, 1) ? SW'(-knee) : SW'(knee);
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// Write one register; the caller lowers the write enable afterwards.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	// Drop valid, drain every outstanding item, then load both registers.
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] drive_raw,
			input logic [CFG_DATA_W-1:0] mode_raw);
		in_valid <= 1'b0;
		while (shaped_q.size() != 0)
			@(negedge clk);
		write_reg(REG_DRIVE_AMOUNT, drive_raw);
		write_reg(REG_CLIP_MODE, mode_raw);
		cfg_we <= 1'b0;
		cur_drive = drive_raw[DRIVE_W-1:0];
		cur_mode = mode_raw[0];
		settings_used++;
	endtask

	// Offer one item at a falling edge and hold it until accepted. Valid stays
	// high on return so the next item can follow without a bubble.
	task automatic send_item(input logic signed [SW-1:0] smp, input logic blk,
			input logic typed, input logic signed [SW-1:0] want);
		shaped_t e;
		in_valid <= 1'b1;
		sample_in <= smp;
		block_end <= blk;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		e.smp = typed ? want : shape_sample(cur_drive, cur_mode, smp);
		e.blk = blk;
		shaped_q.push_back(e);
		items_sent++;
		if (blk)
			ends_sent++;
		@(negedge clk);
	endtask

	// Stimulus: reset, directed table, then random phases under varied settings.
	initial begin
		logic [CFG_DATA_W-1:0] last_drive;
		logic [CFG_DATA_W-1:0] last_mode;
		logic [DRIVE_W-1:0] amt;
		logic mode;
		int burst_left;
		int gap;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the table; reload registers only when a row asks for a new setting.
		// The first rows run on the reset setting without any write.
		last_drive = '0;
		last_mode = {6'h00, MODE_SOFT};
		foreach (shape_rows[i]) begin
			if (shape_rows[i].drive_raw != last_drive || shape_rows[i].mode_raw != last_mode) begin
				apply_setting(shape_rows[i].drive_raw, shape_rows[i].mode_raw);
				last_drive = shape_rows[i].drive_raw;
				last_mode = shape_rows[i].mode_raw;
			end
			send_item(shape_rows[i].smp, shape_rows[i].blk, shape_rows[i].typed,
				shape_rows[i].want);
		end

		// Random phases: the extremes first, then random settings. Mode data
		// carries random upper bits, which the block must ignore.
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin amt = 7'd0;   mode = MODE_SOFT; end
				1: begin amt = 7'd127; mode = MODE_HARD; end
				2: begin amt = 7'd127; mode = MODE_SOFT; end
				3: begin amt = 7'd0;   mode = MODE_HARD; end
				4: begin amt = 7'd1;   mode = MODE_HARD; end
				5: begin amt = 7'd126; mode = MODE_SOFT; end
				default: begin
					amt = DRIVE_W'($urandom());
					mode = $urandom_range(0, 1) ? MODE_HARD : MODE_SOFT;
				end
			endcase
			apply_setting(amt, {6'($urandom()), mode});
			// Ask the receiver for a long hold-off in two phases so the pipe fills.
			if (p == 2 || p == 8)
				squeeze_req = 1'b1;
			burst_left = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(negedge clk);
					end
				end
				burst_left--;
				send_item(pick_sample(amt), $urandom_range(0, 7) == 0, 1'b0, '0);
			end
		end

		// Drain, then watch a little longer for anything stray.
		in_valid <= 1'b0;
		while (shaped_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d items (%0d block ends) over %0d register settings,",
			items_sent, ends_sent, settings_used);
		$display("%0d results checked, %0d long output holds, %0d mismatches.",
			results_seen, holds_done, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver: stall in segments of its own pattern, and hold off for a long
	// counted stretch whenever the stimulus asks for it.
	initial begin
		int seg_len;
		int kind;
		int hold_cnt;
		@(posedge arst_n);
		forever begin
			if (squeeze_req) begin
				out_stall <= 1'b1;
				hold_cnt = 0;
				while (hold_cnt < HOLD_CYCLES) begin
					@(negedge clk);
					hold_cnt++;
				end
				squeeze_req = 1'b0;
				holds_done++;
			end else begin
				kind = $urandom_range(0, 3);
				seg_len = $urandom_range(4, 40);
				for (int c = 0; c < seg_len; c++) begin
					case (kind)
						0: out_stall <= 1'b0;                        // free flow
						1: out_stall <= 1'($urandom_range(0, 1));    // coin flip
						2: out_stall <= (c % 3) == 0;                // stall when c is a multiple of 3
						default: out_stall <= $urandom_range(0, 7) == 0;
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// Check every accepted result against the oldest expectation.
	always @(posedge clk) begin
		shaped_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (shaped_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: sample %0d block_end %0b",
						sample_out, block_end_out);
				mismatches++;
			end else begin
				e = shaped_q.pop_front();
				if (sample_out !== e.smp || block_end_out !== e.blk) begin
					if (mismatches < 10)
						$display("result %0d: sample exp %0d got %0d, block_end exp %0b got %0b",
							results_seen, $signed(e.smp), sample_out, e.blk, block_end_out);
					mismatches++;
				end
			end
		end
	end

	// Timeout, far past the slowest correct run.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ audio_waveshaper_distortion.f @@
rtl/core/awd_pkg.sv
rtl/core/awd_prep.sv
rtl/core/awd_div.sv
rtl/core/awd_post.sv
rtl/core/audio_waveshaper_distortion.sv
tb/tb_top.sv
